// File: src/gcs_pkg.sv
package gcs_pkg;

  // Coefficient registers: unsigned Q0.16 weights, one per tap distance
  localparam int COEF_W    = 16;
  localparam int NUM_COEF  = 5;
  localparam int CFG_IDX_W = 3;

  typedef logic [COEF_W-1:0] coef_t;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OUTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_THIRD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_NEAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTRE = 3'd4;

  // Reset weights, indexed by distance from the center tap
  localparam coef_t COEF_RESET [NUM_COEF] = '{
    16'd15784, 16'd13184, 16'd7683, 16'd3124, 16'd886
  };

endpackage

// File: src/gcs_in_if.sv
interface gcs_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic                         final_point;

  modport source (output valid, output pos_x, output pos_y, output final_point,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input final_point,
                  output ready);
endinterface

// File: src/gcs_out_if.sv
interface gcs_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         final_out;

  modport source (output valid, output out_x, output out_y, output final_out,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input final_out,
                  output ready);
endinterface

// File: src/gcs_cell.sv
// One tap of the window: holds an original point, passes it to its
// neighbor on every accepted word, and registers its weighted product.
module gcs_cell
  import gcs_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int PROD_W     = COORD_BITS + COEF_W + 1
) (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic                         prod_en,
  input  logic signed [COORD_BITS-1:0] nbr_x,
  input  logic signed [COORD_BITS-1:0] nbr_y,
  input  coef_t                        coef,
  output logic signed [COORD_BITS-1:0] pt_x_r,
  output logic signed [COORD_BITS-1:0] pt_y_r,
  output logic signed [PROD_W-1:0]     prod_x_r,
  output logic signed [PROD_W-1:0]     prod_y_r
);

  logic signed [COEF_W:0] wgt;

  assign wgt = signed'({1'b0, coef});

  // point storage, shifts toward the oldest end
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pt_x_r <= nbr_x;
      pt_y_r <= nbr_y;
    end
  end

  // weighted product of the held point
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_x_r <= PROD_W'(pt_x_r * wgt);
      prod_y_r <= PROD_W'(pt_y_r * wgt);
    end
  end

endmodule

// File: src/gcs_reduce.sv
// Sums the tap products of one coordinate: registered group sums, then
// the final add with round-half-up, floor shift and saturation.
module gcs_reduce
  import gcs_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int TAPS       = 9,
  parameter int PROD_W     = COORD_BITS + COEF_W + 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [PROD_W-1:0]     prod [TAPS],
  output logic signed [COORD_BITS-1:0] result
);

  localparam int GRP    = 3;
  localparam int NGRP   = (TAPS + GRP - 1) / GRP;
  localparam int SUM_W  = PROD_W + $clog2(TAPS) + 1;
  localparam int QW     = SUM_W - COEF_W;
  localparam logic signed [SUM_W-1:0] HALF_LSB =
    {{(SUM_W - COEF_W){1'b0}}, 1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [SUM_W-1:0] grp_r   [NGRP];
  logic signed [SUM_W-1:0] grp_nxt [NGRP];
  logic signed [SUM_W-1:0] total;
  logic        [QW-1:0]    quot;
  logic                    fits;

  // group sums of up to three products
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < TAPS) begin
          grp_nxt[g] = grp_nxt[g] + SUM_W'(prod[g * GRP + j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
    end
  end

  // final sum, round half up, floor by the fraction bits
  always_comb begin
    total = HALF_LSB;
    for (int g = 0; g < NGRP; g++) begin
      total = total + grp_r[g];
    end
  end

  assign quot = total[SUM_W-1:COEF_W];
  assign fits = (&quot[QW-1:COORD_BITS-1]) || !(|quot[QW-1:COORD_BITS-1]);

  // clamp to the coordinate range
  always_comb begin
    if (fits) begin
      result = signed'(quot[COORD_BITS-1:0]);
    end else if (quot[QW-1]) begin
      result = COORD_MIN;
    end else begin
      result = COORD_MAX;
    end
  end

endmodule

// File: src/gaussian_curve_smoother_unit.sv
// Gaussian curve smoother: takes one (x, y) curve point per cycle and
// returns each coordinate smoothed by a symmetric FIR of 2*HALF_WIDTH+1
// taps over the original points (Q0.16 weights by tap distance, taps
// beyond distance four weigh zero), rounded half up and saturated. The
// first and last HALF_WIDTH points of a curve pass through unchanged.
// Sustained rate is one word per cycle in and out unless stalled; each
// result passes the window cells, the product registers in the cells,
// the group-sum and output registers. On a final point the input is held
// while the three-stage pipeline drains and then while the tail of the
// window is sent out, one word per cycle unless stalled: HALF_WIDTH
// words, or fewer points for a short curve. The window needs no clearing
// after reset; coefficient writes take effect for the next point.
module gaussian_curve_smoother_unit
  import gcs_pkg::*;
#(
  parameter int HALF_WIDTH = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gcs_in_if.sink                in_ch,
  gcs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  coef_t                 cfg_data
);

  localparam int TAPS   = 2 * HALF_WIDTH + 1;
  localparam int CNT_W  = $clog2(TAPS);
  localparam int PROD_W = COORD_BITS + COEF_W + 1;

  // coefficients, indexed by tap distance
  coef_t coef_r   [NUM_COEF];
  coef_t coef_nxt [NUM_COEF];
  coef_t tap_coef [TAPS];

  // window and products
  logic signed [COORD_BITS-1:0] win_x  [TAPS];
  logic signed [COORD_BITS-1:0] win_y  [TAPS];
  logic signed [PROD_W-1:0]     prod_x [TAPS];
  logic signed [PROD_W-1:0]     prod_y [TAPS];
  logic signed [COORD_BITS-1:0] sm_x;
  logic signed [COORD_BITS-1:0] sm_y;

  // control
  logic             adv;
  logic             in_ready;
  logic             acc;
  logic             flush_go;
  logic             flush_last;
  logic [CNT_W-1:0] first_idx;

  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic             w_v_r, w_v_nxt, w_sm_r, w_sm_nxt;
  logic             p_v_r, p_sm_r, s_v_r, s_sm_r;
  logic signed [COORD_BITS-1:0] p_cx_r, p_cy_r, s_cx_r, s_cy_r;
  logic             flush_busy_r, flush_busy_nxt;
  logic [CNT_W-1:0] flush_idx_r, flush_idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                         out_fin_r, out_fin_nxt;

  // everything moves when the output register can take a word
  assign adv        = !out_valid_r || out_ch.ready;
  assign in_ready   = adv && !flush_busy_r;
  assign acc        = in_ch.valid && in_ready;
  assign flush_go   = flush_busy_r && !w_v_r && !p_v_r && !s_v_r;
  assign flush_last = (flush_idx_r == CNT_W'(TAPS - 1));
  assign first_idx  = (seen_r >= CNT_W'(HALF_WIDTH)) ? CNT_W'(HALF_WIDTH + 1)
                                                     : CNT_W'(2 * HALF_WIDTH) - seen_r;

  // coefficient write decode
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_OUTER:  coef_nxt[4] = cfg_data;
        CFG_COEF_THIRD:  coef_nxt[3] = cfg_data;
        CFG_COEF_SECOND: coef_nxt[2] = cfg_data;
        CFG_COEF_NEAR:   coef_nxt[1] = cfg_data;
        CFG_COEF_CENTRE: coef_nxt[0] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // row of tap cells; the newest point enters at the top
  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    localparam int DIST = (i < HALF_WIDTH) ? HALF_WIDTH - i : i - HALF_WIDTH;
    logic signed [COORD_BITS-1:0] nbr_x, nbr_y;

    if (DIST < NUM_COEF) begin : g_wgt
      assign tap_coef[i] = coef_r[DIST];
    end else begin : g_zero
      assign tap_coef[i] = '0;
    end

    if (i == TAPS - 1) begin : g_head
      assign nbr_x = in_ch.pos_x;
      assign nbr_y = in_ch.pos_y;
    end else begin : g_link
      assign nbr_x = win_x[i + 1];
      assign nbr_y = win_y[i + 1];
    end

    gcs_cell #(
      .COORD_BITS (COORD_BITS),
      .PROD_W     (PROD_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (acc),
      .prod_en  (adv),
      .nbr_x    (nbr_x),
      .nbr_y    (nbr_y),
      .coef     (tap_coef[i]),
      .pt_x_r   (win_x[i]),
      .pt_y_r   (win_y[i]),
      .prod_x_r (prod_x[i]),
      .prod_y_r (prod_y[i])
    );
  end

  gcs_reduce #(
    .COORD_BITS (COORD_BITS),
    .TAPS       (TAPS),
    .PROD_W     (PROD_W)
  ) u_reduce_x (
    .clk    (clk),
    .en     (adv),
    .prod   (prod_x),
    .result (sm_x)
  );

  gcs_reduce #(
    .COORD_BITS (COORD_BITS),
    .TAPS       (TAPS),
    .PROD_W     (PROD_W)
  ) u_reduce_y (
    .clk    (clk),
    .en     (adv),
    .prod   (prod_y),
    .result (sm_y)
  );

  // point count and result descriptor of the accepted word
  always_comb begin
    seen_nxt = seen_r;
    if (acc) begin
      if (in_ch.final_point) begin
        seen_nxt = '0;
      end else if (seen_r < CNT_W'(2 * HALF_WIDTH)) begin
        seen_nxt = seen_r + CNT_W'(1);
      end
    end
    w_v_nxt  = acc && (seen_r >= CNT_W'(HALF_WIDTH));
    w_sm_nxt = (seen_r >= CNT_W'(2 * HALF_WIDTH));
  end

  // tail flush sequencer
  always_comb begin
    flush_busy_nxt = flush_busy_r;
    flush_idx_nxt  = flush_idx_r;
    if (adv && flush_go) begin
      if (flush_last) begin
        flush_busy_nxt = 1'b0;
      end else begin
        flush_idx_nxt = flush_idx_r + CNT_W'(1);
      end
    end
    if (acc && in_ch.final_point) begin
      flush_busy_nxt = 1'b1;
      flush_idx_nxt  = first_idx;
    end
  end

  // output register: pipeline result first, flush words once drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_fin_nxt   = out_fin_r;
    if (adv) begin
      out_valid_nxt = s_v_r || flush_go;
      if (s_v_r) begin
        out_x_nxt   = s_sm_r ? sm_x : s_cx_r;
        out_y_nxt   = s_sm_r ? sm_y : s_cy_r;
        out_fin_nxt = 1'b0;
      end else begin
        out_x_nxt   = win_x[flush_idx_r];
        out_y_nxt   = win_y[flush_idx_r];
        out_fin_nxt = flush_last;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      w_v_r        <= 1'b0;
      p_v_r        <= 1'b0;
      s_v_r        <= 1'b0;
      flush_busy_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      seen_r       <= seen_nxt;
      flush_busy_r <= flush_busy_nxt;
      out_valid_r  <= out_valid_nxt;
      if (adv) begin
        w_v_r <= w_v_nxt;
        p_v_r <= w_v_r;
        s_v_r <= p_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    flush_idx_r <= flush_idx_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_fin_r   <= out_fin_nxt;
    if (adv) begin
      w_sm_r <= w_sm_nxt;
      p_sm_r <= w_sm_r;
      p_cx_r <= win_x[HALF_WIDTH];
      p_cy_r <= win_y[HALF_WIDTH];
      s_sm_r <= p_sm_r;
      s_cx_r <= p_cx_r;
      s_cy_r <= p_cy_r;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.final_out = out_fin_r;

endmodule
